FILE: design/sis_pkg.sv
package sis_pkg;

  localparam int unsigned VALUE_W = 32;

  // one input item as it travels from the front queue to the back end
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } sis_item_t;

endpackage

FILE: design/sis_ram.sv
module sis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sis_front.sv
// Input side: takes items and holds them in a two-entry queue for the back end.
module sis_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic signed [31:0]        value,
  input  logic                      last,
  output logic                      q_valid,
  output sis_pkg::sis_item_t        q_item,
  input  logic                      q_pop
);

  sis_pkg::sis_item_t slot [2];
  logic               wptr;
  logic               rptr;
  logic [1:0]         fill;
  logic               push;
  logic               pop;

  assign item_stall = (fill == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (fill != 2'd0);
  assign pop        = q_pop && q_valid;
  assign q_item     = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr].value <= value;
      slot[wptr].last  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/sis_back.sv
// Back end: stack insertion into the store, then drain in ascending order.
module sis_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  sis_pkg::sis_item_t        q_item,
  output logic                      q_pop,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [31:0]        value_res,
  output logic                      last_res,
  output logic                      overflow
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CMP     = 5'b00010,
    S_PUT     = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT_LD = 5'b10000
  } state_t;

  state_t                               state, state_next;
  logic [CW-1:0]                        count, count_next;
  logic                                 dropped, dropped_next;
  logic [IW-1:0]                        idx, idx_next;
  logic signed [sis_pkg::VALUE_W-1:0]   cur_value;
  logic                                 cur_last;

  logic                                 we, re;
  logic [IW-1:0]                        waddr, raddr;
  logic [sis_pkg::VALUE_W-1:0]          wdata, rdata;

  logic                                 out_free;
  logic                                 load_out;
  logic                                 emit_end;
  logic                                 take;

  sis_ram #(
    .WIDTH (sis_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !res_valid || !res_stall;
  assign take     = (state == S_IDLE) && q_valid;
  assign q_pop    = take;
  assign emit_end = (({1'b0, idx}) + (IW+1)'(1)) == (IW+1)'(count);

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    idx_next     = idx;
    we           = 1'b0;
    waddr        = idx;
    wdata        = cur_value;
    re           = 1'b0;
    raddr        = idx;
    load_out     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (count == FULL) begin
            dropped_next = 1'b1;
            if (q_item.last) begin
              idx_next   = '0;
              state_next = S_EMIT_RD;
            end
          end else if (count == '0) begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = q_item.value;
            count_next = count + CW'(1);
            if (q_item.last) begin
              idx_next   = '0;
              state_next = S_EMIT_RD;
            end
          end else begin
            re         = 1'b1;
            raddr      = IW'(count - CW'(1));
            idx_next   = IW'(count);
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = idx;
        if ($signed(rdata) >= cur_value) begin
          // entry moves one slot down; keep walking toward the top
          wdata = rdata;
          if (idx == IW'(1)) begin
            idx_next   = '0;
            state_next = S_PUT;
          end else begin
            re         = 1'b1;
            raddr      = idx - IW'(2);
            idx_next   = idx - IW'(1);
          end
        end else begin
          wdata      = cur_value;
          count_next = count + CW'(1);
          idx_next   = '0;
          state_next = cur_last ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = cur_value;
        count_next = count + CW'(1);
        idx_next   = '0;
        state_next = cur_last ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        re         = 1'b1;
        raddr      = idx;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          load_out = 1'b1;
          if (emit_end) begin
            count_next   = '0;
            dropped_next = 1'b0;
            idx_next     = '0;
            state_next   = S_IDLE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_value <= q_item.value;
      cur_last  <= q_item.last;
    end
    if (load_out) begin
      value_res <= $signed(rdata);
      last_res  <= emit_end;
      overflow  <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      idx     <= idx_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/stack_insertion_sorter_core.sv
// Stack insertion sorter. Each item carries one signed 32-bit value; the item
// with last set closes the set. Values are kept ascending in a DEPTH-entry
// RAM, smallest at the top. An item is inserted by walking up from the
// bottom of the stack: every entry not smaller than the new value moves one
// slot down, one entry per cycle through the RAM's read/write ports, then the
// value is written into the gap. Insertion into an empty stack, or of a dropped
// value, is finished in the accepting step. Any other insertion takes the
// accepting step, one compare step per moved entry, and one step that writes
// the value (the compare that stops the walk, or a separate write of the top
// slot when every entry moved).
// After the last item, the stack drains top first, each result through a RAM
// read and then the output register, and the count and drop flag clear for
// the next set. Items arriving while the store holds DEPTH values are dropped,
// and every result of that set carries overflow. A two-entry input queue lets
// up to two items wait while an insertion or a drain is in progress. A stalled
// result holds the drain until it is taken; the next result, already read from
// the RAM, loads at the same edge that the held one is taken, and the read of
// the result after it follows.
module stack_insertion_sorter_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] value,
  input  logic               last,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] value_res,
  output logic               last_res,
  output logic               overflow
);

  logic               q_valid;
  logic               q_pop;
  sis_pkg::sis_item_t q_item;

  // front: take items, queue them
  sis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .last       (last),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // back: insert into the stack, drain on last
  sis_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value_res (value_res),
    .last_res  (last_res),
    .overflow  (overflow)
  );

endmodule

FILE: verif/stack_insertion_sorter_core_tb.sv
module stack_insertion_sorter_core_tb;

  localparam int unsigned VALUE_W = sis_pkg::VALUE_W;
  localparam int unsigned DEPTH = 64;
  localparam int RAND_ITEMS = 256;
  // final stretch of the random part runs with no idling on either side
  localparam int CALM_ITEMS = 40;
  // long receiver hold-off, long enough to back the block up into its input
  localparam int LONG_HOLD = 400;
  localparam int NUM_ROWS = 15;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // one expected sorted value
  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic                      fin;
    logic                      ovf;
  } sorted_out_t;

  // directed row: rpt items, value base + i*step, last on the final one if fin
  // is set; typed rows are single-item sets with the result written by hand
  typedef struct packed {
    logic [7:0]                rpt;
    logic signed [VALUE_W-1:0] base;
    logic signed [VALUE_W-1:0] step;
    logic                      fin;
    logic                      typed;
    logic signed [VALUE_W-1:0] exp_val;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      last = 1'b0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic signed [VALUE_W-1:0] value_res;
  logic                      last_res;
  logic                      overflow;

  stack_insertion_sorter_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .value     (value),
    .last      (last),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value_res (value_res),
    .last_res  (last_res),
    .overflow  (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sorted-stack predictor: ascending queue, smallest value at index 0.
  // ---------------------------------------------------------------------
  logic signed [VALUE_W-1:0] model_stack[$];
  logic                      sort_dropped = 1'b0;
  sorted_out_t               pending_sorted[$];

  int errors = 0;
  int items_sent = 0;
  int sets_done = 0;
  int sets_overflowed = 0;
  int results_seen = 0;

  // stimulus -> receiver controls
  logic calm = 1'b0;
  int   hold_req = 0;

  function automatic void sort_model(input logic signed [VALUE_W-1:0] v,
                                     input logic fin);
    int          pos;
    sorted_out_t r;
    pos = 0;
    if (model_stack.size() < DEPTH) begin
      // new value lands above entries equal to it
      while (pos < model_stack.size() && model_stack[pos] < v) pos++;
      model_stack.insert(pos, v);
    end else begin
      // store full: value dropped, flag sticks until the set drains
      sort_dropped = 1'b1;
    end
    if (fin) begin
      foreach (model_stack[k]) begin
        r.val = model_stack[k];
        r.fin = (k == model_stack.size() - 1);
        r.ovf = sort_dropped;
        pending_sorted.push_back(r);
      end
      if (sort_dropped) sets_overflowed++;
      sets_done++;
      model_stack.delete();
      sort_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      // narrow band to force many equal values
      2, 3: return $signed($urandom_range(0, 8)) - 4;
      4: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Drive one item and hold it until accepted. Optional idle burst first.
  task automatic offer_item(input logic signed [VALUE_W-1:0] v, input logic fin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    last       <= fin;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold on request.
  // ---------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        res_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 6);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Each accepted result is matched against the oldest expected one.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin : chk
      sorted_out_t want;
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: value_res %0d last_res %0b overflow %0b",
               value_res, last_res, overflow);
        errors++;
      end else begin
        want = pending_sorted.pop_front();
        results_seen++;
        if (value_res !== want.val) begin
          $error("value_res mismatch: expected %0d, actual %0d", want.val, value_res);
          errors++;
        end
        if (last_res !== want.fin) begin
          $error("last_res mismatch: expected %0b, actual %0b", want.fin, last_res);
          errors++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow mismatch: expected %0b, actual %0b", want.ovf, overflow);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  stim_row_t dir_rows [0:NUM_ROWS-1];

  initial begin
    logic signed [VALUE_W-1:0] v;
    logic                      fin;
    sorted_out_t               typed_res;
    int                        set_no;
    int                        set_size;
    int                        rand_sent;

    // single-item sets: result is the value itself, final, no overflow
    dir_rows[0]  = '{8'd1, VAL_MIN, 32'sd0, 1'b1, 1'b1, VAL_MIN};
    dir_rows[1]  = '{8'd1, VAL_MAX, 32'sd0, 1'b1, 1'b1, VAL_MAX};
    dir_rows[2]  = '{8'd1, 32'sd0,  32'sd0, 1'b1, 1'b1, 32'sd0};
    dir_rows[3]  = '{8'd1, -32'sd1, 32'sd0, 1'b1, 1'b1, -32'sd1};
    // mixed set with extremes and repeated values, closed by a repeat of min
    dir_rows[4]  = '{8'd1, VAL_MAX, 32'sd0, 1'b0, 1'b0, 32'sd0};
    dir_rows[5]  = '{8'd1, VAL_MIN, 32'sd0, 1'b0, 1'b0, 32'sd0};
    dir_rows[6]  = '{8'd1, 32'sd0,  32'sd0, 1'b0, 1'b0, 32'sd0};
    dir_rows[7]  = '{8'd1, -32'sd1, 32'sd0, 1'b0, 1'b0, 32'sd0};
    dir_rows[8]  = '{8'd1, 32'sd1,  32'sd0, 1'b0, 1'b0, 32'sd0};
    dir_rows[9]  = '{8'd1, 32'sd0,  32'sd0, 1'b0, 1'b0, 32'sd0};
    dir_rows[10] = '{8'd1, VAL_MAX, 32'sd0, 1'b0, 1'b0, 32'sd0};
    dir_rows[11] = '{8'd1, VAL_MIN, 32'sd0, 1'b1, 1'b0, 32'sd0};
    // already ascending, then strictly descending, then an equal pair
    dir_rows[12] = '{8'd5, -32'sd10, 32'sd5,   1'b1, 1'b0, 32'sd0};
    dir_rows[13] = '{8'd5, 32'sd100, -32'sd30, 1'b1, 1'b0, 32'sd0};
    dir_rows[14] = '{8'd2, 32'sd7,   32'sd0,   1'b1, 1'b0, 32'sd0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int i = 0; i < dir_rows[r].rpt; i++) begin
        v   = dir_rows[r].base + i * dir_rows[r].step;
        fin = dir_rows[r].fin && (i == dir_rows[r].rpt - 1);
        offer_item(v, fin);
        sort_model(v, fin);
        if (dir_rows[r].typed) begin
          // swap the modelled result for the hand-written one
          void'(pending_sorted.pop_back());
          typed_res.val = dir_rows[r].exp_val;
          typed_res.fin = 1'b1;
          typed_res.ovf = 1'b0;
          pending_sorted.push_back(typed_res);
        end
      end
    end

    // Random sets. Set 1 overfills the store so its last two items are dropped,
    // set 3 fills it exactly; others are mostly short, a few large.
    set_no = 0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (set_no == 1) set_size = DEPTH + 2;
      else if (set_no == 3) set_size = DEPTH;
      else if ($urandom_range(0, 11) == 0) set_size = $urandom_range(DEPTH - 2, DEPTH + 4);
      else set_size = $urandom_range(1, 10);

      if (set_no == 5) begin
        // sender pause until the block has handed back everything
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0) @(posedge clk);
      end

      for (int i = 0; i < set_size; i++) begin
        if (rand_sent >= RAND_ITEMS - CALM_ITEMS) calm <= 1'b1;
        v   = rand_value();
        fin = (i == set_size - 1);
        offer_item(v, fin);
        sort_model(v, fin);
        rand_sent++;
      end

      // receiver holds off while the overfilled set is being offered
      if (set_no == 0) hold_req <= hold_req + 1;
      set_no++;
    end

    item_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (4 * DEPTH) @(posedge clk);

    $display("Run covered %0d items in %0d sets, %0d sorted results checked,",
             items_sent, sets_done, results_seen);
    $display("%0d sets overflowed; extremes, equal values, exact and over-full store,",
             sets_overflowed);
    $display("long output hold-off and a sender pause were included.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
